### hdl/ldfw_pkg.sv
`default_nettype none

package ldfw_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_DIGITS  = 6;
    localparam int DEF_VALUE_WIDTH = 16;

    // Cursor address bases of the two display lines.
    localparam logic [7:0] ROW1_BASE  = 8'h80;
    localparam logic [7:0] ROW2_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] LOW_NIB    = 8'h0F;
    localparam logic [7:0] HIGH_NIB   = 8'hF0;

    // Row codes that carry cursor commands.
    localparam logic [1:0] ROW_LINE1 = 2'd1;
    localparam logic [1:0] ROW_LINE2 = 2'd2;

    // Divide by ten as floor(x * 52428 / 2^19); the estimate is at most one
    // low for x below 2^19 and is corrected by one compare and subtract.
    localparam logic [15:0] RECIP_MUL   = 16'd52428;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [4:0]  DIGIT_TEN   = 5'd10;

    // Nibble phases within one digit.
    localparam logic [1:0] PH_CMD_HI = 2'd0;
    localparam logic [1:0] PH_CMD_LO = 2'd1;
    localparam logic [1:0] PH_DAT_HI = 2'd2;
    localparam logic [1:0] PH_DAT_LO = 2'd3;

    typedef struct packed {
        logic [1:0]  row;
        logic [5:0]  column;
        logic [15:0] value;
        logic [2:0]  digit_count;
    } t_req;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
    } t_resp;

    // Selection handed to the nibble generator.
    typedef struct packed {
        logic [7:0] addr;
        logic [3:0] digit;
        logic [1:0] phase;
    } t_nib_sel;

endpackage

`default_nettype wire

### hdl/ldfw_div10.sv
`default_nettype none

// Shared divide-by-ten unit: the product is registered, the quotient and the
// digit follow in the next cycle while the dividend is held.
module ldfw_div10
    import ldfw_pkg::*;
#(
    parameter int RW = DEF_VALUE_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic [RW-1:0] i_dividend,
    output logic      [RW-1:0] o_quot,
    output logic      [3:0]    o_digit
);

    localparam int PW = RW + 16;

    logic [PW-1:0] r_prod;
    logic [RW-1:0] w_q_est;
    logic [RW-1:0] w_diff;
    logic [4:0]    w_diff5;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_dividend) * PW'(RECIP_MUL);
    end

    assign w_q_est = RW'(r_prod >> RECIP_SHIFT);
    assign w_diff  = i_dividend - (RW'({w_q_est, 3'b000}) + RW'({w_q_est, 1'b0}));
    assign w_diff5 = w_diff[4:0];

    always_comb begin
        if (w_diff5 >= DIGIT_TEN) begin
            o_quot  = w_q_est + RW'(1);
            o_digit = 4'(w_diff5 - DIGIT_TEN);
        end else begin
            o_quot  = w_q_est;
            o_digit = w_diff5[3:0];
        end
    end

endmodule

`default_nettype wire

### hdl/ldfw_nibble.sv
`default_nettype none

// Picks the nibble and register select for one phase of one digit.
module ldfw_nibble
    import ldfw_pkg::*;
(
    input  wire t_nib_sel i_sel,
    output logic          o_rs,
    output logic [3:0]    o_nibble
);

    logic [7:0] w_char;
    logic [7:0] w_hi_addr;
    logic [7:0] w_hi_char;

    assign w_char    = ASCII_ZERO + {4'b0000, i_sel.digit};
    assign w_hi_addr = (i_sel.addr & HIGH_NIB) >> 4;
    assign w_hi_char = (w_char & HIGH_NIB) >> 4;

    always_comb begin
        unique case (i_sel.phase)
            PH_CMD_HI: o_nibble = w_hi_addr[3:0];
            PH_CMD_LO: o_nibble = 4'(i_sel.addr & LOW_NIB);
            PH_DAT_HI: o_nibble = w_hi_char[3:0];
            PH_DAT_LO: o_nibble = 4'(w_char & LOW_NIB);
            default:   o_nibble = 4'b0000;
        endcase
    end

    assign o_rs = i_sel.phase[1];

endmodule

`default_nettype wire

### hdl/lcd_decimal_field_writer.sv
`default_nettype none

// Decimal field writer for a 4-bit character LCD.
// A request on the input channel (i_in_valid, o_in_stall, i_req) carries a
// row, a one-based column, a value and a digit count. The value is cut to
// digit_count decimal digits, clamped to 2 .. MAX_DIGITS, leading zeros kept,
// and for each digit the block sends, on the output channel (o_out_valid, i_out_stall,
// o_resp), two cursor command nibbles (rows 1 and 2 only) and two ASCII data nibbles,
// high nibble first. The final nibble of a request carries last.
// After acceptance each divide-by-ten step passes the product register and
// then the correction; emission follows at one nibble per cycle when not
// stalled. The shared divider paces the conversion and the single output
// register the emission.
// The block stalls its input while a request is being converted or emitted.
// A stalled output nibble holds in the output register; the sequencer waits.
// Reset (synchronous, active low) returns the block to idle with no output.
module lcd_decimal_field_writer
    import ldfw_pkg::*;
#(
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_req  i_req,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_resp      o_resp
);

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int RW = VALUE_WIDTH;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [RW-1:0] r_rem, n_rem;
    logic [IW-1:0] r_last_idx, n_last_idx;
    logic [IW-1:0] r_widx, n_widx;
    logic [IW-1:0] r_k, n_k;
    logic [1:0]    r_phase, n_phase;
    logic          r_cursor, n_cursor;
    logic [7:0]    r_addr, n_addr;
    logic          r_out_valid, n_out_valid;
    t_resp         r_resp, n_resp;

    // Digits, most significant at index zero.
    logic [3:0]    r_dig [MAX_DIGITS];

    logic          w_accept;
    logic          w_emit;
    logic          w_dig_we;
    logic [RW-1:0] w_quot;
    logic [3:0]    w_digit;
    t_nib_sel      w_sel;
    logic          w_rs;
    logic [3:0]    w_nibble;
    logic          w_last;
    logic [7:0]    w_base;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_emit   = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_dig_we = (r_state == S_FIX);

    ldfw_div10 #(
        .RW(RW)
    ) u_div10 (
        .i_clk      (i_clk),
        .i_dividend (r_rem),
        .o_quot     (w_quot),
        .o_digit    (w_digit)
    );

    assign w_sel.addr  = r_addr;
    assign w_sel.digit = r_dig[r_k];
    assign w_sel.phase = r_phase;

    ldfw_nibble u_nibble (
        .i_sel    (w_sel),
        .o_rs     (w_rs),
        .o_nibble (w_nibble)
    );

    assign w_last = (r_phase == PH_DAT_LO) && (r_k == r_last_idx);

    always_comb begin
        if (i_req.row == ROW_LINE1) begin
            w_base = ROW1_BASE;
        end else begin
            w_base = ROW2_BASE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_last_idx  = r_last_idx;
        n_widx      = r_widx;
        n_k         = r_k;
        n_phase     = r_phase;
        n_cursor    = r_cursor;
        n_addr      = r_addr;
        n_out_valid = r_out_valid;
        n_resp      = r_resp;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Count below two is raised, above the maximum lowered.
                    if (int'(i_req.digit_count) < 2) begin
                        n_last_idx = IW'(1);
                    end else if (int'(i_req.digit_count) > MAX_DIGITS) begin
                        n_last_idx = IW'(MAX_DIGITS - 1);
                    end else begin
                        n_last_idx = IW'(int'(i_req.digit_count) - 1);
                    end
                    n_widx   = n_last_idx;
                    n_rem    = RW'(i_req.value);
                    n_cursor = (i_req.row == ROW_LINE1) || (i_req.row == ROW_LINE2);
                    // A column of zero gives the address just below the row base.
                    n_addr   = 8'(w_base + {2'b00, i_req.column} - 8'd1);
                    n_k      = '0;
                    n_phase  = n_cursor ? PH_CMD_HI : PH_DAT_HI;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                // Least significant digit first, filled from the right.
                n_rem = w_quot;
                if (r_widx == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_widx  = r_widx - IW'(1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid            = 1'b1;
                    n_resp.register_select = w_rs;
                    n_resp.nibble          = w_nibble;
                    n_resp.last            = w_last;
                    if (r_phase == PH_DAT_LO) begin
                        n_k     = r_k + IW'(1);
                        n_addr  = r_addr + 8'd1;
                        n_phase = r_cursor ? PH_CMD_HI : PH_DAT_HI;
                        if (w_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_last_idx <= n_last_idx;
        r_widx     <= n_widx;
        r_k        <= n_k;
        r_phase    <= n_phase;
        r_cursor   <= n_cursor;
        r_addr     <= n_addr;
        r_resp     <= n_resp;
    end

    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_dig[r_widx] <= w_digit;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_resp      = r_resp;

    // An accepted request always starts digit conversion.
    a_accept_converts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL))
        else $error("accepted request did not start conversion");

    // Rows without cursor commands never emit a command phase.
    a_no_cmd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !r_cursor) |-> r_phase[1])
        else $error("command phase reached on a row without cursor commands");

    // The final nibble of a request is always a character data nibble.
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_resp.last) |-> o_resp.register_select)
        else $error("last nibble is not a data nibble");

    // Emission only begins after at least one correction step.
    a_emit_after_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && ($past(r_state) != S_EMIT)) |-> ($past(r_state) == S_FIX))
        else $error("emission entered without a conversion step");

endmodule

`default_nettype wire

### dv/tb_lcd_decimal_field_writer.sv
`timescale 1ns / 1ps

module tb_lcd_decimal_field_writer;
    import ldfw_pkg::*;

    // Rows 0 and 3 carry no cursor commands; only the two line rows do.
    localparam logic [1:0] ROW_BLANK_LO = 2'd0;
    localparam logic [1:0] ROW_BLANK_HI = 2'd3;

    localparam int MAX_DIGITS   = DEF_MAX_DIGITS;
    localparam int IDLE_PERCENT = 18;
    localparam int RANDOM_ITEMS = 353;
    // The drain runs well past the longest request.
    localparam int DRAIN_CYCLES = 80;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    t_req  req_bus = '0;
    logic  out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_resp o_resp;

    // Requests waiting to be sent and nibbles the display stream still owes.
    t_req  pending_requests[$];
    t_resp nibbles_due[$];

    int    requests_taken = 0;
    int    fault_count = 0;
    logic  calm;

    lcd_decimal_field_writer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (req_bus),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_resp      (o_resp)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Both sides run without any idling while this window of requests goes
    // through, so that back-to-back traffic is covered as well.
    assign calm = (requests_taken >= 120) && (requests_taken < 200);

    // Only the first ten faults are printed in full; the rest are counted.
    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                        input logic is_last);
        t_resp item;
        item.register_select = rs;
        item.nibble          = nib;
        item.last            = is_last;
        nibbles_due.push_back(item);
    endfunction

    // Works out the whole nibble stream that one request must produce: the
    // value is cut to its decimal digits, leading zeros kept, and each digit
    // becomes an optional cursor address pair followed by an ASCII pair.
    function automatic void queue_field_nibbles(input t_req rq);
        int unsigned digits;
        int unsigned modulus;
        int unsigned rest;
        int          total;
        int          idx;
        logic [3:0]  digit_of [MAX_DIGITS];
        logic        cursor;
        logic [7:0]  base;
        logic [7:0]  addr;
        logic [7:0]  ch;
        // Counts outside the legal range are clamped to 2 .. MAX_DIGITS.
        digits = rq.digit_count;
        if (digits < 2) begin
            digits = 2;
        end
        if (digits > MAX_DIGITS) begin
            digits = MAX_DIGITS;
        end
        modulus = 1;
        for (int i = 0; i < digits; i++) begin
            modulus *= 10;
        end
        rest = rq.value % modulus;
        for (int i = digits - 1; i >= 0; i--) begin
            digit_of[i] = 4'(rest % 10);
            rest /= 10;
        end
        cursor = (rq.row == ROW_LINE1) || (rq.row == ROW_LINE2);
        base   = (rq.row == ROW_LINE2) ? ROW2_BASE : ROW1_BASE;
        total  = cursor ? 4 * digits : 2 * digits;
        idx    = 0;
        for (int i = 0; i < digits; i++) begin
            ch = ASCII_ZERO + 8'(digit_of[i]);
            if (cursor) begin
                // The column is one-based; column zero falls just below the row base
                // and large columns simply wrap within the 8-bit address.
                addr = 8'(base + rq.column + i - 1);
                push_nibble(1'b0, addr[7:4], idx == total - 1);
                idx++;
                push_nibble(1'b0, addr[3:0], idx == total - 1);
                idx++;
            end
            push_nibble(1'b1, ch[7:4], idx == total - 1);
            idx++;
            push_nibble(1'b1, ch[3:0], idx == total - 1);
            idx++;
        end
    endfunction

    function automatic t_req make_request(input logic [1:0] row, input logic [5:0] column,
                                          input logic [15:0] value, input logic [2:0] count);
        t_req rq;
        rq.row         = row;
        rq.column      = column;
        rq.value       = value;
        rq.digit_count = count;
        return rq;
    endfunction

    // Random request: the value mix favors the digit boundaries (powers of
    // ten and their neighbors, the top of the range, single digits), and
    // about one in eight counts falls outside 2 .. 6 to hit the clamping.
    function automatic t_req random_request();
        logic [1:0]  row;
        logic [5:0]  column;
        logic [15:0] value;
        logic [2:0]  count;
        int unsigned pick;
        int unsigned power;
        row = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) begin
            column = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end else begin
            column = 6'($urandom_range(0, 63));
        end
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            value = 16'($urandom);
        end else if (pick <= 6) begin
            value = 16'($urandom_range(0, 999));
        end else if (pick == 7) begin
            power = 10;
            repeat ($urandom_range(0, 3)) power *= 10;
            value = 16'(power + $urandom_range(0, 2) - 1);
        end else if (pick == 8) begin
            value = 16'(65535 - $urandom_range(0, 99));
        end else begin
            value = 16'($urandom_range(0, 9));
        end
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0: count = 3'd0;
                1: count = 3'd1;
                default: count = 3'd7;
            endcase
        end else begin
            count = 3'($urandom_range(2, 6));
        end
        return make_request(row, column, value, count);
    endfunction

    // Request driver. A request is taken at an edge where valid is high and
    // the block does not stall. Valid is only reconsidered once the current
    // request has gone, so a stalled request stays put, and each edge sees
    // at most one assignment to valid.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                queue_field_nibbles(req_bus);
                requests_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    in_valid <= 1'b1;
                    req_bus  <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Nibble monitor. Every accepted nibble is matched, field by field,
    // against the oldest outstanding expectation; the stall toward the block
    // is redrawn every cycle outside the calm window.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (nibbles_due.size() == 0) begin
                    note_fault($sformatf("nibble with none expected: rs=%0d nibble=%h last=%0d",
                                         o_resp.register_select, o_resp.nibble,
                                         o_resp.last));
                end else if (o_resp.register_select !== nibbles_due[0].register_select ||
                             o_resp.nibble !== nibbles_due[0].nibble ||
                             o_resp.last !== nibbles_due[0].last) begin
                    note_fault($sformatf(
                        "expected rs=%0d nibble=%h last=%0d, got rs=%0d nibble=%h last=%0d",
                        nibbles_due[0].register_select, nibbles_due[0].nibble,
                        nibbles_due[0].last, o_resp.register_select, o_resp.nibble,
                        o_resp.last));
                    void'(nibbles_due.pop_front());
                end else begin
                    void'(nibbles_due.pop_front());
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Watchdog: far beyond the slowest legal run of this request load.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        // Directed requests: field extremes, both line rows and both blank
        // rows, column zero, address wrap past 0xFF, and counts below two and
        // above the maximum.
        pending_requests.push_back(make_request(ROW_LINE1, 6'd1, 16'd0, 3'd2));
        pending_requests.push_back(make_request(ROW_LINE2, 6'd1, 16'd65535, 3'd6));
        pending_requests.push_back(make_request(ROW_BLANK_LO, 6'd5, 16'd12345, 3'd5));
        pending_requests.push_back(make_request(ROW_BLANK_HI, 6'd63, 16'd65535, 3'd4));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd0, 16'd42, 3'd3));
        pending_requests.push_back(make_request(ROW_LINE2, 6'd0, 16'd7, 3'd2));
        pending_requests.push_back(make_request(ROW_LINE2, 6'd63, 16'd99, 3'd6));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd63, 16'd65535, 3'd6));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd10, 16'd123, 3'd0));
        pending_requests.push_back(make_request(ROW_LINE2, 6'd10, 16'd456, 3'd1));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd20, 16'd65535, 3'd7));
        pending_requests.push_back(make_request(ROW_BLANK_HI, 6'd1, 16'd9999, 3'd4));
        pending_requests.push_back(make_request(ROW_BLANK_LO, 6'd0, 16'd10000, 3'd4));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd42, 16'd100, 3'd2));
        pending_requests.push_back(make_request(ROW_LINE2, 6'd21, 16'd54321, 3'd3));
        pending_requests.push_back(make_request(ROW_BLANK_LO, 6'd63, 16'd0, 3'd7));
        pending_requests.push_back(make_request(ROW_LINE1, 6'd1, 16'd1000, 3'd5));
        repeat (RANDOM_ITEMS) pending_requests.push_back(random_request());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has been taken and every nibble seen,
        // then give the block time to show any stray output.
        @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || nibbles_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
